FILE: hdl/scaled_font_text_rasterizer_assert.svh
// Assertion macros used by the checker file.
`ifndef SCALED_FONT_TEXT_RASTERIZER_ASSERT_SVH
`define SCALED_FONT_TEXT_RASTERIZER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SFTR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SFTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: hdl/sftr_pkg.sv
// Package with constants, types and the glyph table of the text rasterizer.
package sftr_pkg;
	localparam int DEF_FRAME_WIDTH  = 400;
	localparam int DEF_FRAME_HEIGHT = 300;

	typedef enum logic [1:0] {
		ACT_BEGIN = 2'd0,
		ACT_CHAR  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	localparam logic [7:0] CODE_END   = 8'd0;
	localparam logic [7:0] CODE_LF    = 8'd10;
	localparam logic [7:0] CODE_FIRST = 8'd32;
	localparam logic [7:0] CODE_LAST  = 8'd127;
	localparam logic [7:0] CODE_QMARK = 8'h3F;
	localparam logic [7:0] BYTE_WHITE = 8'hFF;

	typedef enum logic [1:0] {
		CMD_GLYPH = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		logic [6:0]  glyph;
		logic [9:0]  gx;
		logic [9:0]  gy;
		logic [2:0]  gs;
		logic [13:0] addr;
	} cmd_t;

	function automatic logic [39:0] glyph_bits(input logic [6:0] g);
		logic [39:0] r;
		case (g)
			7'd0:  r = {8'h00,8'h00,8'h00,8'h00,8'h00};
			7'd1:  r = {8'h00,8'h00,8'h5F,8'h00,8'h00};
			7'd2:  r = {8'h00,8'h07,8'h00,8'h07,8'h00};
			7'd3:  r = {8'h14,8'h7F,8'h14,8'h7F,8'h14};
			7'd4:  r = {8'h24,8'h2A,8'h7F,8'h2A,8'h12};
			7'd5:  r = {8'h23,8'h13,8'h08,8'h64,8'h62};
			7'd6:  r = {8'h36,8'h49,8'h55,8'h22,8'h50};
			7'd7:  r = {8'h00,8'h05,8'h03,8'h00,8'h00};
			7'd8:  r = {8'h00,8'h1C,8'h22,8'h41,8'h00};
			7'd9:  r = {8'h00,8'h41,8'h22,8'h1C,8'h00};
			7'd10: r = {8'h14,8'h08,8'h3E,8'h08,8'h14};
			7'd11: r = {8'h08,8'h08,8'h3E,8'h08,8'h08};
			7'd12: r = {8'h00,8'h50,8'h30,8'h00,8'h00};
			7'd13: r = {8'h08,8'h08,8'h08,8'h08,8'h08};
			7'd14: r = {8'h00,8'h60,8'h60,8'h00,8'h00};
			7'd15: r = {8'h20,8'h10,8'h08,8'h04,8'h02};
			7'd16: r = {8'h3E,8'h51,8'h49,8'h45,8'h3E};
			7'd17: r = {8'h00,8'h42,8'h7F,8'h40,8'h00};
			7'd18: r = {8'h42,8'h61,8'h51,8'h49,8'h46};
			7'd19: r = {8'h21,8'h41,8'h45,8'h4B,8'h31};
			7'd20: r = {8'h18,8'h14,8'h12,8'h7F,8'h10};
			7'd21: r = {8'h27,8'h45,8'h45,8'h45,8'h39};
			7'd22: r = {8'h3C,8'h4A,8'h49,8'h49,8'h30};
			7'd23: r = {8'h01,8'h71,8'h09,8'h05,8'h03};
			7'd24: r = {8'h36,8'h49,8'h49,8'h49,8'h36};
			7'd25: r = {8'h06,8'h49,8'h49,8'h29,8'h1E};
			7'd26: r = {8'h00,8'h36,8'h36,8'h00,8'h00};
			7'd27: r = {8'h00,8'h56,8'h36,8'h00,8'h00};
			7'd28: r = {8'h08,8'h14,8'h22,8'h41,8'h00};
			7'd29: r = {8'h14,8'h14,8'h14,8'h14,8'h14};
			7'd30: r = {8'h00,8'h41,8'h22,8'h14,8'h08};
			7'd31: r = {8'h02,8'h01,8'h51,8'h09,8'h06};
			7'd32: r = {8'h32,8'h49,8'h79,8'h41,8'h3E};
			7'd33: r = {8'h7E,8'h11,8'h11,8'h11,8'h7E};
			7'd34: r = {8'h7F,8'h49,8'h49,8'h49,8'h36};
			7'd35: r = {8'h3E,8'h41,8'h41,8'h41,8'h22};
			7'd36: r = {8'h7F,8'h41,8'h41,8'h22,8'h1C};
			7'd37: r = {8'h7F,8'h49,8'h49,8'h49,8'h41};
			7'd38: r = {8'h7F,8'h09,8'h09,8'h09,8'h01};
			7'd39: r = {8'h3E,8'h41,8'h49,8'h49,8'h7A};
			7'd40: r = {8'h7F,8'h08,8'h08,8'h08,8'h7F};
			7'd41: r = {8'h00,8'h41,8'h7F,8'h41,8'h00};
			7'd42: r = {8'h20,8'h40,8'h41,8'h3F,8'h01};
			7'd43: r = {8'h7F,8'h08,8'h14,8'h22,8'h41};
			7'd44: r = {8'h7F,8'h40,8'h40,8'h40,8'h40};
			7'd45: r = {8'h7F,8'h02,8'h04,8'h02,8'h7F};
			7'd46: r = {8'h7F,8'h04,8'h08,8'h10,8'h7F};
			7'd47: r = {8'h3E,8'h41,8'h41,8'h41,8'h3E};
			7'd48: r = {8'h7F,8'h09,8'h09,8'h09,8'h06};
			7'd49: r = {8'h3E,8'h41,8'h51,8'h21,8'h5E};
			7'd50: r = {8'h7F,8'h09,8'h19,8'h29,8'h46};
			7'd51: r = {8'h46,8'h49,8'h49,8'h49,8'h31};
			7'd52: r = {8'h01,8'h01,8'h7F,8'h01,8'h01};
			7'd53: r = {8'h3F,8'h40,8'h40,8'h40,8'h3F};
			7'd54: r = {8'h1F,8'h20,8'h40,8'h20,8'h1F};
			7'd55: r = {8'h3F,8'h40,8'h38,8'h40,8'h3F};
			7'd56: r = {8'h63,8'h14,8'h08,8'h14,8'h63};
			7'd57: r = {8'h07,8'h08,8'h70,8'h08,8'h07};
			7'd58: r = {8'h61,8'h51,8'h49,8'h45,8'h43};
			7'd59: r = {8'h00,8'h7F,8'h41,8'h41,8'h00};
			7'd60: r = {8'h02,8'h04,8'h08,8'h10,8'h20};
			7'd61: r = {8'h00,8'h41,8'h41,8'h7F,8'h00};
			7'd62: r = {8'h04,8'h02,8'h01,8'h02,8'h04};
			7'd63: r = {8'h40,8'h40,8'h40,8'h40,8'h40};
			7'd64: r = {8'h00,8'h03,8'h07,8'h08,8'h00};
			7'd65: r = {8'h20,8'h54,8'h54,8'h54,8'h78};
			7'd66: r = {8'h7F,8'h48,8'h44,8'h44,8'h38};
			7'd67: r = {8'h38,8'h44,8'h44,8'h44,8'h20};
			7'd68: r = {8'h38,8'h44,8'h44,8'h48,8'h7F};
			7'd69: r = {8'h38,8'h54,8'h54,8'h54,8'h18};
			7'd70: r = {8'h08,8'h7E,8'h09,8'h01,8'h02};
			7'd71: r = {8'h0C,8'h52,8'h52,8'h52,8'h3E};
			7'd72: r = {8'h7F,8'h08,8'h04,8'h04,8'h78};
			7'd73: r = {8'h00,8'h44,8'h7D,8'h40,8'h00};
			7'd74: r = {8'h20,8'h40,8'h44,8'h3D,8'h00};
			7'd75: r = {8'h7F,8'h10,8'h28,8'h44,8'h00};
			7'd76: r = {8'h00,8'h41,8'h7F,8'h40,8'h00};
			7'd77: r = {8'h7C,8'h04,8'h18,8'h04,8'h78};
			7'd78: r = {8'h7C,8'h08,8'h04,8'h04,8'h78};
			7'd79: r = {8'h38,8'h44,8'h44,8'h44,8'h38};
			7'd80: r = {8'h7C,8'h14,8'h14,8'h14,8'h08};
			7'd81: r = {8'h08,8'h14,8'h14,8'h18,8'h7C};
			7'd82: r = {8'h7C,8'h08,8'h04,8'h04,8'h08};
			7'd83: r = {8'h48,8'h54,8'h54,8'h54,8'h20};
			7'd84: r = {8'h04,8'h3F,8'h44,8'h40,8'h20};
			7'd85: r = {8'h3C,8'h40,8'h40,8'h20,8'h7C};
			7'd86: r = {8'h1C,8'h20,8'h40,8'h20,8'h1C};
			7'd87: r = {8'h3C,8'h40,8'h30,8'h40,8'h3C};
			7'd88: r = {8'h44,8'h28,8'h10,8'h28,8'h44};
			7'd89: r = {8'h0C,8'h50,8'h50,8'h50,8'h3C};
			7'd90: r = {8'h44,8'h64,8'h54,8'h4C,8'h44};
			7'd91: r = {8'h00,8'h08,8'h36,8'h41,8'h00};
			7'd92: r = {8'h00,8'h00,8'h7F,8'h00,8'h00};
			7'd93: r = {8'h00,8'h41,8'h36,8'h08,8'h00};
			7'd94: r = {8'h08,8'h04,8'h08,8'h10,8'h08};
			default: r = '0;
		endcase
		return r;
	endfunction

	// Column col (0 leftmost) of a glyph, bit 0 the top row.
	function automatic logic [6:0] glyph_col(input logic [6:0] g, input logic [2:0] col);
		logic [39:0] w;
		logic [39:0] sh;
		w = glyph_bits(g);
		sh = w >> (6'(3'd4 - col) * 6'd8);
		return sh[6:0];
	endfunction
endpackage

FILE: hdl/sftr_if.sv
// Valid/ready stream interface used by both channels.
interface sftr_if #(parameter int W = 8) (input logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/sftr_ram.sv
// Generic single-port RAM with registered read.
module sftr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: hdl/sftr_front.sv
// Front end: holds cursor state, classifies items and issues commands.
module sftr_front import sftr_pkg::*; #(
	parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
	parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [8:0]  origin_x,
	input  logic [8:0]  origin_y,
	input  logic [2:0]  scale,
	input  logic [7:0]  char_code,
	input  logic [13:0] byte_address,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);
	logic [9:0] cursor_x_q, cursor_y_q;
	logic [8:0] line_start_x_q;
	logic [2:0] glyph_scale_q;
	logic       stopped_q;

	logic [5:0]  s5, s6, s7, s9;
	logic [10:0] right_edge, nl_y, nl_bottom;
	logic        wrap, nl_stop;
	logic [6:0]  glyph;
	logic        acc;
	logic        issue;
	cmd_op_t     op_d;
	logic [9:0]  gx_d, gy_d;

	assign s5 = 6'(glyph_scale_q) * 6'd5;
	assign s6 = 6'(glyph_scale_q) * 6'd6;
	assign s7 = 6'(glyph_scale_q) * 6'd7;
	assign s9 = 6'(glyph_scale_q) * 6'd9;
	assign right_edge = 11'(cursor_x_q) + 11'(s5);
	assign nl_y = 11'(cursor_y_q) + 11'(s9);
	assign nl_bottom = nl_y + 11'(s7);
	assign wrap = right_edge >= 11'(FRAME_WIDTH);
	assign nl_stop = nl_bottom >= 11'(FRAME_HEIGHT);
	assign glyph = (char_code < CODE_FIRST || char_code > CODE_LAST) ?
		7'(CODE_QMARK - CODE_FIRST) : 7'(char_code - CODE_FIRST);
	assign gx_d = wrap ? 10'(line_start_x_q) : cursor_x_q;
	assign gy_d = wrap ? nl_y[9:0] : cursor_y_q;

	assign in_ready = !cmd_valid || cmd_ready;
	assign acc = in_valid && in_ready;

	always_comb begin
		issue = 1'b0;
		op_d = CMD_READ;
		case (action_t'(action))
			ACT_CHAR: begin
				op_d = CMD_GLYPH;
				issue = !stopped_q && char_code != CODE_END && char_code != CODE_LF &&
					!(wrap && nl_stop);
			end
			ACT_CLEAR: begin
				op_d = CMD_CLEAR;
				issue = 1'b1;
			end
			ACT_READ: begin
				op_d = CMD_READ;
				issue = 1'b1;
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			line_start_x_q <= '0;
			glyph_scale_q <= 3'd1;
			stopped_q <= 1'b1;
			cmd_valid <= 1'b0;
		end else begin
			if (acc) begin
				cmd_valid <= issue;
			end else if (cmd_ready) begin
				cmd_valid <= 1'b0;
			end
			if (acc) begin
				cmd.op <= op_d;
				cmd.addr <= byte_address;
				cmd.glyph <= glyph;
				cmd.gs <= glyph_scale_q;
				cmd.gx <= gx_d;
				cmd.gy <= gy_d;
				case (action_t'(action))
					ACT_BEGIN: begin
						line_start_x_q <= origin_x;
						cursor_x_q <= 10'(origin_x);
						cursor_y_q <= 10'(origin_y);
						glyph_scale_q <= (scale == 3'd0) ? 3'd1 : (scale > 3'd4) ? 3'd4 : scale;
						stopped_q <= 1'b0;
					end
					ACT_CHAR: begin
						if (!stopped_q) begin
							if (char_code == CODE_END) begin
								stopped_q <= 1'b1;
							end else if (char_code == CODE_LF) begin
								cursor_x_q <= 10'(line_start_x_q);
								cursor_y_q <= nl_y[9:0];
								stopped_q <= nl_stop;
							end else if (wrap && nl_stop) begin
								cursor_x_q <= 10'(line_start_x_q);
								cursor_y_q <= nl_y[9:0];
								stopped_q <= 1'b1;
							end else if (wrap) begin
								cursor_x_q <= 10'(11'(line_start_x_q) + 11'(s6));
								cursor_y_q <= nl_y[9:0];
							end else begin
								cursor_x_q <= 10'(11'(cursor_x_q) + 11'(s6));
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end
endmodule

FILE: hdl/sftr_back.sv
// Back end: clears the store, paints glyphs by read-modify-write, serves reads.
module sftr_back import sftr_pkg::*; #(
	parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
	parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT,
	parameter int STORE_BYTES  = (FRAME_WIDTH * FRAME_HEIGHT + 7) / 8,
	parameter int AW           = $clog2(STORE_BYTES)
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] frame_byte
);
	typedef enum logic [2:0] {
		ST_INIT, ST_IDLE, ST_DOT, ST_RD, ST_WR, ST_RDWAIT, ST_RDDONE, ST_OUT
	} state_t;

	state_t      state_q;
	cmd_t        c_q;
	logic [AW:0] clr_q;
	logic [2:0]  col_q, row_q;
	logic [1:0]  dx_q, dy_q;
	logic        oob_q;
	logic [AW-1:0] waddr_q;
	logic [2:0]  bit_q;
	logic        dot_q;

	logic          we;
	logic [AW-1:0] addr;
	logic [7:0]    wdata, rdata;
	logic [6:0]    colbits;
	logic [10:0]   px, py;
	logic [20:0]   lin;
	logic          last_d;

	assign colbits = glyph_col(c_q.glyph, col_q);
	assign px = 11'(c_q.gx) + 11'(6'(col_q) * 6'(c_q.gs)) + 11'(dx_q);
	assign py = 11'(c_q.gy) + 11'(6'(row_q) * 6'(c_q.gs)) + 11'(dy_q);
	assign lin = 21'(py) * 21'(FRAME_WIDTH) + 21'(px);
	assign last_d = (3'(dx_q) == c_q.gs - 3'd1) && (3'(dy_q) == c_q.gs - 3'd1);

	always_comb begin
		we = 1'b0;
		wdata = BYTE_WHITE;
		addr = waddr_q;
		case (state_q)
			ST_INIT: begin
				we = 1'b1;
				addr = clr_q[AW-1:0];
			end
			ST_WR: begin
				we = dot_q;
				wdata = rdata & ~(8'h80 >> bit_q);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	sftr_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	assign cmd_ready = state_q == ST_IDLE;
	assign out_valid = state_q == ST_OUT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			clr_q <= '0;
		end else begin
			case (state_q)
				ST_INIT: begin
					if (clr_q == (AW+1)'(STORE_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
					clr_q <= clr_q + 1'b1;
				end
				ST_IDLE: begin
					c_q <= cmd;
					col_q <= '0;
					row_q <= '0;
					dx_q <= '0;
					dy_q <= '0;
					waddr_q <= AW'(cmd.addr);
					oob_q <= 32'(cmd.addr) >= 32'(STORE_BYTES);
					clr_q <= '0;
					if (cmd_valid) begin
						case (cmd.op)
							CMD_GLYPH: state_q <= ST_DOT;
							CMD_CLEAR: state_q <= ST_INIT;
							default: state_q <= ST_RDWAIT;
						endcase
					end
				end
				ST_DOT: begin
					if (colbits[row_q] && px < 11'(FRAME_WIDTH) && py < 11'(FRAME_HEIGHT)) begin
						waddr_q <= lin[AW+2:3];
						bit_q <= lin[2:0];
						dot_q <= 1'b1;
						state_q <= ST_RD;
					end else begin
						dot_q <= 1'b0;
						state_q <= ST_WR;
					end
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					state_q <= ST_DOT;
					if (!last_d) begin
						if (3'(dy_q) == c_q.gs - 3'd1) begin
							dy_q <= '0;
							dx_q <= dx_q + 1'b1;
						end else begin
							dy_q <= dy_q + 1'b1;
						end
					end else begin
						dx_q <= '0;
						dy_q <= '0;
						if (row_q == 3'd6) begin
							row_q <= '0;
							if (col_q == 3'd4) begin
								state_q <= ST_IDLE;
							end else begin
								col_q <= col_q + 1'b1;
							end
						end else begin
							row_q <= row_q + 1'b1;
						end
					end
				end
				ST_RDWAIT: state_q <= ST_RDDONE;
				ST_RDDONE: begin
					frame_byte <= oob_q ? 8'h00 : rdata;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: hdl/scaled_font_text_rasterizer.sv
// A read passes the command register and the back end's RDWAIT and RDDONE states before its
// byte is presented. A glyph takes a start step in IDLE, then a DOT and a WR step for each
// sub-pixel of its cell and an RD step for each black one; the back end takes no new command
// until it is done, as all work shares the single frame RAM port. A clear writes each store byte.
// Reset is asynchronous and active low; it clears the cursor state and starts a clearing
// pass over every store byte, during which no command is carried out.
module scaled_font_text_rasterizer import sftr_pkg::*; #(
	parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
	parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
	input logic clk,
	input logic arst_n,
	sftr_if.sink   in_ch,
	sftr_if.source out_ch
);
	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	sftr_front #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.action(in_ch.data[1:0]), .origin_x(in_ch.data[10:2]),
		.origin_y(in_ch.data[19:11]), .scale(in_ch.data[22:20]),
		.char_code(in_ch.data[30:23]), .byte_address(in_ch.data[44:31]),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	sftr_back #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.frame_byte(out_ch.data[7:0])
	);
endmodule

FILE: hdl/sftr_checker.sv
// Port-level checker for the text rasterizer and its bind.
`include "scaled_font_text_rasterizer_assert.svh"
module sftr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_data
);
	`SFTR_ASSERT_NEXT(out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`SFTR_ASSERT_IMP(no_reset_out, clk, arst_n, $rose(arst_n), !out_valid)
	`SFTR_ASSERT_NEXT(out_one, clk, arst_n, out_valid && out_ready, !out_valid)
	`SFTR_ASSERT_NEXT(in_hold, clk, arst_n, in_valid && !in_ready, in_valid)
endmodule

bind scaled_font_text_rasterizer sftr_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data[7:0])
);
